FILE: hw/rtl/ims_pkg.sv
// shared types and constants for the ising metropolis spin-flip block
// controller/datapath command and status structs, state codes, field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ims_pkg;

  // fixed field widths
  localparam int SIZE_W     = 7;
  localparam int THR_W      = 17;
  localparam int ROW_W      = 6;
  localparam int DE_W       = 5;
  localparam int MAG_W      = 14;
  localparam int ENE_W      = 15;
  localparam int REG_ADDR_W = 4;
  localparam int REG_DATA_W = 32;
  localparam int OUT_W      = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // register index codes, taken from paddr[3:2]
  localparam logic [1:0] REG_LATTICE_SIZE = 2'd0;
  localparam logic [1:0] REG_THR_DE4      = 2'd1;
  localparam logic [1:0] REG_THR_DE8      = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_C,
    ST_READ_U,
    ST_READ_D,
    ST_CALC,
    ST_WIPE,
    ST_RESULT
  } ims_state_t;

  typedef enum logic [1:0] {
    RD_CENTER,
    RD_UP,
    RD_DOWN
  } ims_rd_sel_t;

  typedef struct packed {
    logic        take;
    logic        rd_en;
    ims_rd_sel_t rd_sel;
    logic        cap_center;
    logic        cap_up;
    logic        do_update;
    logic        set_bad;
    logic        set_restart;
    logic        clear_step;
    logic        load_totals;
    logic        load_out;
  } ims_cmd_t;

  typedef struct packed {
    logic is_restart;
    logic is_bad;
    logic clr_first;
    logic clr_last;
    logic out_busy;
  } ims_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ising_metropolis_spin_flip.sv
// top level of the 2d ising metropolis single-spin-flip block
// depends on ims_pkg, ims_regs, ims_ctrl, ims_dp (which holds ims_ram)
//
// channel   direction  handshake                    contents
// s_*       in         s_tvalid / s_tready          update or restart request word
// m_*       out        m_tvalid / m_tready          result word
// apb       in         psel, penable, pwrite        lattice_size, thresholds
//
// an update steps through three lattice row reads on the single ram read
// port, a state to decide and write back, and a state to move the result into
// the output register, which waits while that register is still full. a restart
// rewrites the ram one row per cycle. after reset a clearing pass runs before
// the first word is accepted; config is taken throughout. a result waiting in
// the output register does not block the next accept, only the next result load.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_spin_flip #(
  parameter int MAX_SIDE    = 64,
  parameter int RANDOM_BITS = 16,
  localparam int IN_W = ((12 + RANDOM_BITS + 7) / 8) * 8,
  localparam int SW   = $clog2(MAX_SIDE + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // row[5:0], col[11:6], random_value[12 +: RANDOM_BITS], zero fill
  input  wire logic [IN_W-1:0]                   s_tdata,
  // req_type
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // flipped[0], spin_after[1], delta_energy[6:2], magnetization[20:7],
  // total_energy[35:21], zero fill
  output logic [ims_pkg::OUT_W-1:0]              m_tdata,
  // bad_site
  output logic                                   m_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ims_pkg::REG_ADDR_W-1:0]    paddr,
  input  wire logic [ims_pkg::REG_DATA_W-1:0]    pwdata,
  output logic      [ims_pkg::REG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  logic [SW-1:0]             side;
  logic [ims_pkg::THR_W-1:0] thr_de4;
  logic [ims_pkg::THR_W-1:0] thr_de8;

  ims_pkg::ims_cmd_t  cmd;
  ims_pkg::ims_stat_t stat;

  logic                                   flipped;
  logic                                   spin_after;
  logic signed [ims_pkg::DE_W-1:0]        delta_energy;
  logic signed [ims_pkg::MAG_W-1:0]       magnetization;
  logic signed [ims_pkg::ENE_W-1:0]       total_energy;

  ims_regs #(
    .MAX_SIDE (MAX_SIDE)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .side    (side),
    .thr_de4 (thr_de4),
    .thr_de8 (thr_de8)
  );

  ims_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ims_dp #(
    .MAX_SIDE    (MAX_SIDE),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .req_type          (s_tuser),
    .row               (s_tdata[5:0]),
    .col               (s_tdata[11:6]),
    .random_value      (s_tdata[12 +: RANDOM_BITS]),
    .side              (side),
    .thr_de4           (thr_de4),
    .thr_de8           (thr_de8),
    .out_ready         (m_tready),
    .out_valid         (m_tvalid),
    .out_flipped       (flipped),
    .out_spin_after    (spin_after),
    .out_delta_energy  (delta_energy),
    .out_magnetization (magnetization),
    .out_total_energy  (total_energy),
    .out_bad_site      (m_tuser)
  );

  assign m_tdata = {4'b0000, total_energy, magnetization, delta_energy, spin_after, flipped};

  // one word in flight: the block is busy in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while one is in work");

  // a bad site result carries no flip, no spin and no energy change
  a_bad_site_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[6:0] == 7'd0)
    else $error("bad site result has nonzero update fields");

  // a flip only happens for an energy change that is a multiple of four
  a_flip_de: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[3:2] == 2'b00 && !m_tuser)
    else $error("flip reported with impossible energy change");

endmodule

`default_nettype wire

FILE: hw/rtl/ims_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ims_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ims_regs.sv
// configuration registers behind the apb-style port, plus side clamping
// depends on ims_pkg
`timescale 1ns / 1ps
`default_nettype none

module ims_regs #(
  parameter int MAX_SIDE = 64,
  localparam int SW = $clog2(MAX_SIDE + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ims_pkg::REG_ADDR_W-1:0]    paddr,
  input  wire logic [ims_pkg::REG_DATA_W-1:0]    pwdata,
  output logic      [ims_pkg::REG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [SW-1:0]                     side,
  output logic      [ims_pkg::THR_W-1:0]         thr_de4,
  output logic      [ims_pkg::THR_W-1:0]         thr_de8
);

  localparam int CW = (SW > ims_pkg::SIZE_W) ? SW : ims_pkg::SIZE_W;

  logic [ims_pkg::SIZE_W-1:0] lattice_size;
  logic [1:0]                 reg_idx;
  logic                       wr;
  logic [CW-1:0]              size_x;
  logic [CW-1:0]              side_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_size <= ims_pkg::SIZE_RESET;
      thr_de4      <= '0;
      thr_de8      <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        ims_pkg::REG_LATTICE_SIZE: lattice_size <= pwdata[ims_pkg::SIZE_W-1:0];
        ims_pkg::REG_THR_DE4:      thr_de4      <= pwdata[ims_pkg::THR_W-1:0];
        ims_pkg::REG_THR_DE8:      thr_de8      <= pwdata[ims_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ims_pkg::REG_LATTICE_SIZE: prdata = ims_pkg::REG_DATA_W'(lattice_size);
      ims_pkg::REG_THR_DE4:      prdata = ims_pkg::REG_DATA_W'(thr_de4);
      ims_pkg::REG_THR_DE8:      prdata = ims_pkg::REG_DATA_W'(thr_de8);
      default:                   prdata = '0;
    endcase
  end

  // side in use is clamped to 2..MAX_SIDE
  assign size_x = CW'(lattice_size);

  always_comb begin
    if (size_x < CW'(2)) begin
      side_full = CW'(2);
    end else if (size_x > CW'(MAX_SIDE)) begin
      side_full = CW'(MAX_SIDE);
    end else begin
      side_full = size_x;
    end
  end

  assign side = side_full[SW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/ims_ctrl.sv
// controller state machine: sequences lattice reads, update, clearing pass
// and result hand-off; depends on ims_pkg
`timescale 1ns / 1ps
`default_nettype none

module ims_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire ims_pkg::ims_stat_t stat,
  output ims_pkg::ims_cmd_t       cmd
);

  ims_pkg::ims_state_t state;
  ims_pkg::ims_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ims_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ims_pkg::ST_INIT: begin
        if (stat.clr_last) state_next = ims_pkg::ST_IDLE;
      end
      ims_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ims_pkg::ST_READ_C;
      end
      ims_pkg::ST_READ_C: begin
        if (stat.is_restart) begin
          state_next = ims_pkg::ST_WIPE;
        end else if (stat.is_bad) begin
          state_next = ims_pkg::ST_RESULT;
        end else begin
          state_next = ims_pkg::ST_READ_U;
        end
      end
      ims_pkg::ST_READ_U: state_next = ims_pkg::ST_READ_D;
      ims_pkg::ST_READ_D: state_next = ims_pkg::ST_CALC;
      ims_pkg::ST_CALC:   state_next = ims_pkg::ST_RESULT;
      ims_pkg::ST_WIPE: begin
        if (stat.clr_last) state_next = ims_pkg::ST_RESULT;
      end
      ims_pkg::ST_RESULT: begin
        if (!stat.out_busy) state_next = ims_pkg::ST_IDLE;
      end
      default: state_next = ims_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = ims_pkg::RD_CENTER;
    s_tready = 1'b0;
    unique case (state) inside
      ims_pkg::ST_INIT, ims_pkg::ST_WIPE: begin
        cmd.clear_step  = 1'b1;
        cmd.load_totals = stat.clr_first;
      end
      ims_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      ims_pkg::ST_READ_C: begin
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = ims_pkg::RD_CENTER;
        cmd.set_restart = stat.is_restart;
        cmd.set_bad     = stat.is_bad & ~stat.is_restart;
      end
      ims_pkg::ST_READ_U: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = ims_pkg::RD_UP;
        cmd.cap_center = 1'b1;
      end
      ims_pkg::ST_READ_D: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ims_pkg::RD_DOWN;
        cmd.cap_up = 1'b1;
      end
      ims_pkg::ST_CALC: begin
        cmd.do_update = 1'b1;
      end
      ims_pkg::ST_RESULT: begin
        cmd.load_out = ~stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ims_dp.sv
// datapath: spin lattice ram (one row per word), neighbor selection,
// metropolis accept, running totals, result and output registers
// depends on ims_pkg and ims_ram
`timescale 1ns / 1ps
`default_nettype none

module ims_dp #(
  parameter int MAX_SIDE    = 64,
  parameter int RANDOM_BITS = 16,
  localparam int SW = $clog2(MAX_SIDE + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ims_pkg::ims_cmd_t                  cmd,
  output ims_pkg::ims_stat_t                      stat,
  input  wire logic                               req_type,
  input  wire logic [ims_pkg::ROW_W-1:0]          row,
  input  wire logic [ims_pkg::ROW_W-1:0]          col,
  input  wire logic [RANDOM_BITS-1:0]             random_value,
  input  wire logic [SW-1:0]                      side,
  input  wire logic [ims_pkg::THR_W-1:0]          thr_de4,
  input  wire logic [ims_pkg::THR_W-1:0]          thr_de8,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic                                    out_flipped,
  output logic                                    out_spin_after,
  output logic signed [ims_pkg::DE_W-1:0]         out_delta_energy,
  output logic signed [ims_pkg::MAG_W-1:0]        out_magnetization,
  output logic signed [ims_pkg::ENE_W-1:0]        out_total_energy,
  output logic                                    out_bad_site
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int RW = (SW > ims_pkg::ROW_W) ? SW : ims_pkg::ROW_W;
  localparam int TW = (RANDOM_BITS > ims_pkg::THR_W) ? RANDOM_BITS : ims_pkg::THR_W;
  localparam int PW = (2 * SW > ims_pkg::ENE_W) ? 2 * SW : ims_pkg::ENE_W;

  // latched item
  logic                   item_req;
  logic [RW-1:0]          item_row;
  logic [RW-1:0]          item_col;
  logic [RANDOM_BITS-1:0] item_rnd;

  logic [RW-1:0] side_x;
  logic [SW-1:0] side_m1_full;
  logic [AW-1:0] side_m1;
  logic [AW-1:0] row_a;
  logic [AW-1:0] col_a;
  logic [AW-1:0] up_a;
  logic [AW-1:0] down_a;
  logic [AW-1:0] left_a;
  logic [AW-1:0] right_a;

  // lattice ram
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [MAX_SIDE-1:0] ram_wr_data;
  logic [AW-1:0]       ram_rd_addr;
  logic [MAX_SIDE-1:0] ram_rd_data;

  logic [MAX_SIDE-1:0] center_row;
  logic [MAX_SIDE-1:0] new_row;
  logic                up_bit;
  logic                spin;
  logic [2:0]          same_cnt;
  logic                lt_de4;
  logic                lt_de8;
  logic                accept;
  logic signed [ims_pkg::DE_W-1:0] de;

  logic [AW-1:0] clr_cnt;

  logic signed [ims_pkg::MAG_W-1:0] mag;
  logic signed [ims_pkg::ENE_W-1:0] ene;
  logic [PW-1:0]                    n_full;
  logic [ims_pkg::ENE_W-1:0]        n15;

  logic                            res_flip;
  logic                            res_spin;
  logic signed [ims_pkg::DE_W-1:0] res_de;
  logic                            res_bad;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_req <= req_type;
      item_row <= RW'(row);
      item_col <= RW'(col);
      item_rnd <= random_value;
    end
  end

  assign side_x       = RW'(side);
  assign side_m1_full = side - 1'b1;
  assign side_m1      = side_m1_full[AW-1:0];
  assign row_a        = item_row[AW-1:0];
  assign col_a        = item_col[AW-1:0];

  assign stat.is_restart = item_req;
  assign stat.is_bad     = (item_row >= side_x) || (item_col >= side_x);

  // periodic neighbors
  assign up_a    = (row_a == '0) ? side_m1 : AW'(row_a - 1'b1);
  assign down_a  = (row_a == side_m1) ? '0 : AW'(row_a + 1'b1);
  assign left_a  = (col_a == '0) ? side_m1 : AW'(col_a - 1'b1);
  assign right_a = (col_a == side_m1) ? '0 : AW'(col_a + 1'b1);

  always_comb begin
    case (cmd.rd_sel)
      ims_pkg::RD_UP:   ram_rd_addr = up_a;
      ims_pkg::RD_DOWN: ram_rd_addr = down_a;
      default:          ram_rd_addr = row_a;
    endcase
  end

  ims_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_lattice (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_center) center_row <= ram_rd_data;
    if (cmd.cap_up)     up_bit     <= ram_rd_data[col_a];
  end

  // down row arrives on the read port during the update cycle
  assign spin     = center_row[col_a];
  assign same_cnt = 3'(up_bit == spin) + 3'(ram_rd_data[col_a] == spin)
                  + 3'(center_row[left_a] == spin) + 3'(center_row[right_a] == spin);

  // de = 4 * (neighbors equal to the spin) - 8
  assign de = signed'(5'({same_cnt, 2'b00}) - 5'd8);

  assign lt_de4 = TW'(item_rnd) < TW'(thr_de4);
  assign lt_de8 = TW'(item_rnd) < TW'(thr_de8);

  always_comb begin
    case (same_cnt)
      3'd3:    accept = lt_de4;
      3'd4:    accept = lt_de8;
      default: accept = 1'b1;
    endcase
  end

  always_comb begin
    new_row        = center_row;
    new_row[col_a] = ~spin;
  end

  assign ram_wr_en   = cmd.clear_step | (cmd.do_update & accept);
  assign ram_wr_addr = cmd.clear_step ? clr_cnt : row_a;
  assign ram_wr_data = cmd.clear_step ? '1 : new_row;

  // clearing pass, one row per cycle
  assign stat.clr_first = (clr_cnt == '0);
  assign stat.clr_last  = (clr_cnt == AW'(MAX_SIDE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= stat.clr_last ? '0 : AW'(clr_cnt + 1'b1);
    end
  end

  // restart totals from n = side squared
  assign n_full = PW'(side) * PW'(side);
  assign n15    = n_full[ims_pkg::ENE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_totals) begin
      mag <= signed'(n15[ims_pkg::MAG_W-1:0]);
      ene <= signed'(ims_pkg::ENE_W'(0) - {n15[ims_pkg::MAG_W-1:0], 1'b0});
    end else if (cmd.do_update && accept) begin
      mag <= spin ? mag - 14'sd2 : mag + 14'sd2;
      ene <= ene + {{(ims_pkg::ENE_W - ims_pkg::DE_W){de[ims_pkg::DE_W-1]}}, de};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_bad) begin
      res_flip <= 1'b0;
      res_spin <= 1'b0;
      res_de   <= '0;
      res_bad  <= 1'b1;
    end else if (cmd.set_restart) begin
      res_flip <= 1'b0;
      res_spin <= 1'b1;
      res_de   <= '0;
      res_bad  <= 1'b0;
    end else if (cmd.do_update) begin
      res_flip <= accept;
      res_spin <= accept ? ~spin : spin;
      res_de   <= de;
      res_bad  <= 1'b0;
    end
  end

  // output register
  assign stat.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_flipped       <= res_flip;
      out_spin_after    <= res_spin;
      out_delta_energy  <= res_de;
      out_magnetization <= mag;
      out_total_energy  <= ene;
      out_bad_site      <= res_bad;
    end
  end

endmodule

`default_nettype wire
